[sv/csi_pkg.sv]
// Shared types, widths and helpers for the coherent Stokes integrator.
// Used by every module of the block except csi_ram; no dependencies.
`default_nettype none
package csi_pkg;

   localparam int MAX_SAMPLES     = 1024;
   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_INTEGRATION = 64;

   localparam int SLOT_W = $clog2(MAX_SAMPLES);
   localparam int WIN_W  = $clog2(MAX_INTEGRATION);
   localparam int TI_W   = 7;
   localparam int SPB_W  = 11;
   localparam int CSR_W  = 11;

   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int VAL_W  = PROD_W + 2;

   localparam int I_W = 45;
   localparam int Q_W = 45;
   localparam int U_W = 46;
   localparam int V_W = 46;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      CSR_ALL_STOKES  = 2'd0,
      CSR_TIME_INTEG  = 2'd1,
      CSR_CHAN_INTEG  = 2'd2,
      CSR_SAMPLES_BLK = 2'd3
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // per-item control decided at acceptance
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              first;
      logic              emit;
      logic              done;
   } ctl_type;

   typedef struct packed {
      logic [I_W-1:0]        i;
      logic signed [Q_W-1:0] q;
      logic signed [U_W-1:0] u;
      logic signed [V_W-1:0] v;
   } sums_type;

   localparam int SUMS_W = $bits(sums_type);

   typedef struct packed {
      sums_type          sums;
      logic [SLOT_W-1:0] slot;
      logic              done;
   } result_type;

   function automatic logic [TI_W-1:0] clamp_integ(input logic [TI_W-1:0] v);
      logic [TI_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = TI_W'(1);
      end else if (v > TI_W'(MAX_INTEGRATION)) begin
         r = TI_W'(MAX_INTEGRATION);
      end
      return r;
   endfunction

   function automatic logic [SPB_W-1:0] clamp_block(input logic [SPB_W-1:0] v);
      logic [SPB_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SPB_W'(1);
      end else if (v > SPB_W'(MAX_SAMPLES)) begin
         r = SPB_W'(MAX_SAMPLES);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/csi_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old contents.
`default_nettype none
module csi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/csi_ctrl.sv]
// Configuration registers and time/window/channel position counters.
// Produces the per-item control word. Depends on csi_pkg.
`default_nettype none
module csi_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [csi_pkg::CSR_W-1:0]    csr_wdata,
   input  wire logic                         accept,
   output csi_pkg::ctl_type                  ctl,
   output logic                              all_stokes
);
   import csi_pkg::*;

   logic              all_stokes_ff;
   logic [TI_W-1:0]   ti_ff;
   logic [TI_W-1:0]   ci_ff;
   logic [SPB_W-1:0]  spb_ff;

   logic [SLOT_W-1:0] time_pos_ff, time_pos_in;
   logic [WIN_W-1:0]  win_pos_ff, win_pos_in;
   logic [WIN_W-1:0]  chan_ff, chan_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [TI_W-1:0]   ti_eff, ci_eff;
   logic [SPB_W-1:0]  spb_eff;
   logic              block_end, win_end, grp_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         all_stokes_ff <= 1'b1;
         ti_ff         <= TI_W'(1);
         ci_ff         <= TI_W'(1);
         spb_ff        <= SPB_W'(MAX_SAMPLES);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ALL_STOKES:  all_stokes_ff <= csr_wdata[0];
            CSR_TIME_INTEG:  ti_ff         <= csr_wdata[TI_W-1:0];
            CSR_CHAN_INTEG:  ci_ff         <= csr_wdata[TI_W-1:0];
            CSR_SAMPLES_BLK: spb_ff        <= csr_wdata[SPB_W-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      ti_eff    = clamp_integ(ti_ff);
      ci_eff    = clamp_integ(ci_ff);
      spb_eff   = clamp_block(spb_ff);
      block_end = (SPB_W'(time_pos_ff) + SPB_W'(1)) >= spb_eff;
      win_end   = block_end || ((TI_W'(win_pos_ff) + TI_W'(1)) >= ti_eff);
      grp_end   = (TI_W'(chan_ff) + TI_W'(1)) >= ci_eff;
   end

   always_comb begin
      time_pos_in = time_pos_ff;
      win_pos_in  = win_pos_ff;
      chan_in     = chan_ff;
      slot_in     = slot_ff;
      if (csr_wr_en) begin
         time_pos_in = '0;
         win_pos_in  = '0;
         chan_in     = '0;
         slot_in     = '0;
      end else if (accept) begin
         if (block_end) begin
            time_pos_in = '0;
            win_pos_in  = '0;
            slot_in     = '0;
            chan_in     = grp_end ? '0 : chan_ff + WIN_W'(1);
         end else begin
            time_pos_in = time_pos_ff + SLOT_W'(1);
            win_pos_in  = win_end ? '0 : win_pos_ff + WIN_W'(1);
            slot_in     = win_end ? slot_ff + SLOT_W'(1) : slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_pos_ff <= '0;
         win_pos_ff  <= '0;
         chan_ff     <= '0;
         slot_ff     <= '0;
      end else begin
         time_pos_ff <= time_pos_in;
         win_pos_ff  <= win_pos_in;
         chan_ff     <= chan_in;
         slot_ff     <= slot_in;
      end
   end

   always_comb begin
      ctl.slot   = slot_ff;
      ctl.first  = (chan_ff == '0) && (win_pos_ff == '0);
      ctl.emit   = win_end && grp_end;
      ctl.done   = block_end;
      all_stokes = all_stokes_ff;
   end

endmodule
`default_nettype wire

[sv/csi_accum.sv]
// Stokes datapath: products, Stokes terms, read-modify-write of the
// per-slot accumulator RAM with forwarding. Depends on csi_pkg, csi_ram.
`default_nettype none
module csi_accum (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire csi_pkg::sample_type  x_re,
   input  wire csi_pkg::sample_type  x_im,
   input  wire csi_pkg::sample_type  y_re,
   input  wire csi_pkg::sample_type  y_im,
   input  wire csi_pkg::ctl_type     ctl,
   input  wire logic                 all_stokes,
   output logic [1:0]                inflight,
   output logic                      push,
   output csi_pkg::result_type       push_data
);
   import csi_pkg::*;

   // stage 1: products
   logic                     v1_ff;
   ctl_type                  ctl1_ff;
   logic                     stokes1_ff;
   logic signed [PROD_W-1:0] xrxr_ff, xixi_ff, yryr_ff, yiyi_ff;
   logic signed [PROD_W-1:0] xryr_ff, xiyi_ff, xiyr_ff, xryi_ff;

   // stage 2: Stokes terms, accumulate
   logic                     v2_ff;
   ctl_type                  ctl2_ff;
   logic signed [VAL_W-1:0]  vi_ff, vq_ff, vu_ff, vv_ff;
   logic                     fwd_ff;
   sums_type                 last_wr_ff;

   logic signed [PROD_W:0]   px, py, re_xy, im_xy;
   logic signed [VAL_W-1:0]  vi_in, vq_in, vu_in, vv_in;
   logic [SUMS_W-1:0]        rd_data;
   sums_type                 old_sums, new_sums;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctl1_ff    <= ctl;
      stokes1_ff <= all_stokes;
      xrxr_ff    <= PROD_W'(x_re) * PROD_W'(x_re);
      xixi_ff    <= PROD_W'(x_im) * PROD_W'(x_im);
      yryr_ff    <= PROD_W'(y_re) * PROD_W'(y_re);
      yiyi_ff    <= PROD_W'(y_im) * PROD_W'(y_im);
      xryr_ff    <= PROD_W'(x_re) * PROD_W'(y_re);
      xiyi_ff    <= PROD_W'(x_im) * PROD_W'(y_im);
      xiyr_ff    <= PROD_W'(x_im) * PROD_W'(y_re);
      xryi_ff    <= PROD_W'(x_re) * PROD_W'(y_im);
   end

   always_comb begin
      px    = (PROD_W+1)'(xrxr_ff) + (PROD_W+1)'(xixi_ff);
      py    = (PROD_W+1)'(yryr_ff) + (PROD_W+1)'(yiyi_ff);
      re_xy = (PROD_W+1)'(xryr_ff) + (PROD_W+1)'(xiyi_ff);
      im_xy = (PROD_W+1)'(xiyr_ff) - (PROD_W+1)'(xryi_ff);
      vi_in = VAL_W'(px) + VAL_W'(py);
      vq_in = '0;
      vu_in = '0;
      vv_in = '0;
      if (stokes1_ff) begin
         vq_in = VAL_W'(px) - VAL_W'(py);
         vu_in = {re_xy, 1'b0};
         vv_in = {im_xy, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      ctl2_ff <= ctl1_ff;
      vi_ff   <= vi_in;
      vq_ff   <= vq_in;
      vu_ff   <= vu_in;
      vv_ff   <= vv_in;
      // the RAM read for stage 1 misses a write landing in the same cycle
      fwd_ff  <= v1_ff && v2_ff && (ctl1_ff.slot == ctl2_ff.slot);
      if (v2_ff) begin
         last_wr_ff <= new_sums;
      end
   end

   always_comb begin
      old_sums = fwd_ff ? last_wr_ff : sums_type'(rd_data);
      if (ctl2_ff.first) begin
         old_sums = '0;
      end
      new_sums.i = old_sums.i + I_W'(vi_ff);
      new_sums.q = old_sums.q + Q_W'(vq_ff);
      new_sums.u = old_sums.u + U_W'(vu_ff);
      new_sums.v = old_sums.v + V_W'(vv_ff);
   end

   csi_ram #(
      .WIDTH (SUMS_W),
      .DEPTH (MAX_SAMPLES)
   ) u_sums_ram (
      .clock   (clock),
      .wr_en   (v2_ff),
      .wr_addr (ctl2_ff.slot),
      .wr_data (SUMS_W'(new_sums)),
      .rd_addr (ctl1_ff.slot),
      .rd_data (rd_data)
   );

   always_comb begin
      inflight       = {1'b0, v1_ff} + {1'b0, v2_ff};
      push           = v2_ff && ctl2_ff.emit;
      push_data.sums = new_sums;
      push_data.slot = ctl2_ff.slot;
      push_data.done = ctl2_ff.done;
   end

endmodule
`default_nettype wire

[sv/csi_fifo.sv]
// Small result queue between the accumulator pipeline and the rsp channel.
// Depends on csi_pkg.
`default_nettype none
module csi_fifo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire csi_pkg::result_type         push_data,
   input  wire logic                        pop_ready,
   output logic                             pop_valid,
   output csi_pkg::result_type              pop_data,
   output logic [csi_pkg::FIFO_CW-1:0]      count
);
   import csi_pkg::*;

   result_type         entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0] count_ff;
   logic               pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
      end
   end

endmodule
`default_nettype wire

[sv/coherent_stokes_integrator_unit.sv]
// Coherent Stokes integrator, top level.
// Depends on csi_pkg, csi_ctrl, csi_accum, csi_fifo, csi_ram.
//
// Usage:
//  - req_*: one dual-polarization complex sample per transfer, channel by
//    channel, time order within a channel over samples_per_block samples.
//  - rsp_*: integrated I/Q/U/V for one output time slot, sent at the last
//    sample of each time window in the last channel of a channel group;
//    rsp_group_done marks the one at the end of the block.
//  - csr_*: write-only registers (all_stokes, time_integrations,
//    channel_integrations, samples_per_block); any write restarts the block.
//    Write only while no results are pending.
//  - Throughput: one sample per clock while req_ready is high. A result is
//    pushed into the output queue from the accumulate stage, after the
//    product stage, and shows on rsp_* when it heads the queue. The
//    registered accumulator RAM read is covered by forwarding the prior write.
//  - Stall: a four-entry result queue absorbs rsp backpressure; req_ready
//    drops when queued results plus in-flight samples fill it.
//  - Reset: counters restart at slot zero, registers take their defaults.
//    Accumulator RAM is not cleared; the first sample of each window in the
//    first channel of a group overwrites its slot.
`default_nettype none
module coherent_stokes_integrator_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [15:0]          req_x_re,
   input  wire logic signed [15:0]          req_x_im,
   input  wire logic signed [15:0]          req_y_re,
   input  wire logic signed [15:0]          req_y_im,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [44:0]                      rsp_stokes_i,
   output logic signed [44:0]               rsp_stokes_q,
   output logic signed [45:0]               rsp_stokes_u,
   output logic signed [45:0]               rsp_stokes_v,
   output logic [9:0]                       rsp_out_slot,
   output logic                             rsp_group_done,
   input  wire logic                        csr_wr_en,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [csi_pkg::CSR_W-1:0]   csr_wdata
);
   import csi_pkg::*;

   ctl_type            ctl;
   logic               all_stokes;
   logic               accept;
   logic [1:0]         inflight;
   logic               push;
   result_type         push_data;
   result_type         pop_data;
   logic [FIFO_CW-1:0] count;
   logic [FIFO_CW:0]   occupancy;

   assign occupancy = (FIFO_CW+1)'(count) + (FIFO_CW+1)'(inflight);
   assign req_ready = occupancy < (FIFO_CW+1)'(FIFO_DEPTH);
   assign accept    = req_valid && req_ready;

   csi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .ctl        (ctl),
      .all_stokes (all_stokes)
   );

   csi_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .x_re       (req_x_re),
      .x_im       (req_x_im),
      .y_re       (req_y_re),
      .y_im       (req_y_im),
      .ctl        (ctl),
      .all_stokes (all_stokes),
      .inflight   (inflight),
      .push       (push),
      .push_data  (push_data)
   );

   csi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_ready),
      .pop_valid (rsp_valid),
      .pop_data  (pop_data),
      .count     (count)
   );

   assign rsp_stokes_i   = pop_data.sums.i;
   assign rsp_stokes_q   = pop_data.sums.q;
   assign rsp_stokes_u   = pop_data.sums.u;
   assign rsp_stokes_v   = pop_data.sums.v;
   assign rsp_out_slot   = pop_data.slot;
   assign rsp_group_done = pop_data.done;

endmodule
`default_nettype wire
